// File: rtl/pbe_pkg.sv
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared types, constants and helpers for the printable bitset engine.
// ----------------------------------------------------------------------------
package pbe_pkg;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_TEST   = 3'd1,
    KIND_NEXT   = 3'd2,
    KIND_SET    = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_READ   = 3'd5,
    KIND_EMPTY  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BADCHAR = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic [7:0]  CH_BASE       = 8'h20;
  localparam logic [7:0]  CH_LAST       = 8'h5f;
  localparam logic [7:0]  CH_SPACE      = 8'h20;
  localparam logic [5:0]  SIX_MASK      = 6'h3f;
  localparam logic [10:0] MAX_BITS_RST  = 11'd1200;
  // floor(x/6) = (x*683) >> 12 for every 11-bit x
  localparam logic [9:0]  RECIP_6       = 10'd683;
  localparam int unsigned RECIP_SHIFT   = 12;
  localparam logic [11:0] RES_NONE      = 12'hfff;
  localparam int unsigned BITS_PER_CHAR = 6;

  // six payload bits carried by a stored character
  function automatic logic [5:0] six_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_BASE;
    return d[5:0] & SIX_MASK;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v);
    return {2'b00, v & SIX_MASK} + CH_BASE;
  endfunction

  // lowest set bit of a nonzero six-bit value
  function automatic logic [2:0] lowest_bit(input logic [5:0] v);
    logic [2:0] b;
    b = 3'd5;
    for (int i = 4; i >= 0; i--) begin
      if (v[i]) begin
        b = 3'(i);
      end
    end
    return b;
  endfunction

endpackage

// File: rtl/pbe_ram.sv
// ----------------------------------------------------------------------------
// pbe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/printable_bitset_engine.sv
// ----------------------------------------------------------------------------
// printable_bitset_engine
// Bit string kept six bits per printable character, with find-next-set-bit.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command per transfer: tuser is the kind, tdata holds
//   bit_index and char_in. m_axis returns exactly one result per command:
//   tdata holds result_value, char_out and length_out, tuser the status.
//   cfg_we_i / cfg_wdata_i load max_bits; use only while idle (not enforced).
// timing:
//   one command is in flight at a time; s_axis_tready_o is low from accept
//   until the result has been moved into the output register, and the next
//   command can be taken in the same cycle as the result turns valid.
//   append, empty, and commands rejected up front: S_DIV, S_REM, S_DISP,
//   then S_OUT. test, read and clear: also one read of the character store
//   through its registered read port; clear then writes the character back.
//   set: first one space per character padded in (S_PAD), then the read and
//   the write back. find-next: one read per character visited, bounded by the length.
// reset: string length clears to zero, max_bits returns to 1200; the store
//   contents stay undefined and are only read below the length.
// stall: the result register holds while m_axis_tready_i is low; a finished
//   command waits until its result has a place in that register.
// ----------------------------------------------------------------------------
module printable_bitset_engine #(
  parameter  int unsigned MAX_CHARS = 256,
  localparam int unsigned LEN_W     = $clog2(MAX_CHARS + 1),
  localparam int unsigned OD_W      = ((20 + LEN_W + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration: max_bits
  input  logic            cfg_we_i,
  input  logic [10:0]     cfg_wdata_i,
  // commands
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [23:0]     s_axis_tdata_i,  // [10:0] bit_index, [18:11] char_in
  input  logic [2:0]      s_axis_tuser_i,  // [2:0] kind
  // results
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OD_W-1:0] m_axis_tdata_o,  // result_value, char_out, length_out
  output logic [1:0]      m_axis_tuser_o   // [1:0] status
);

  import pbe_pkg::*;

  localparam int unsigned ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int unsigned CW     = (LEN_W > 11) ? LEN_W : 11;
  localparam int unsigned PW     = (CW > 12) ? CW : 12;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_CHARS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_DISP,
    S_PAD,
    S_RD,
    S_USE,
    S_OUT
  } state_e;

  state_e          state_q;
  kind_e           kind_q;
  logic [10:0]     idx_q;
  logic [7:0]      ch_q;
  logic [8:0]      pos_q;
  logic [2:0]      bit_q;
  logic [CW-1:0]   addr_q;
  logic [5:0]      mask_q;
  logic [LEN_W-1:0] len_q;
  logic [10:0]     max_bits_q;
  logic [11:0]     res_q;
  logic [7:0]      cout_q;
  status_e         status_q;
  logic            m_valid_q;
  logic [11:0]     m_res_q;
  logic [7:0]      m_cout_q;
  logic [1:0]      m_status_q;
  logic [LEN_W-1:0] m_len_q;

  // character store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  logic [20:0]   prod;
  logic [10:0]   q6;
  logic [CW-1:0] len_cw;
  logic [CW-1:0] pos_cw;
  logic [CW-1:0] idx_cw;
  logic [CW-1:0] addr_inc;
  logic [5:0]    v_rd;
  logic [5:0]    v_hit;
  logic [5:0]    v_mod;
  logic [PW-1:0] addr_pw;
  logic [11:0]   base_bit;
  logic          out_free;
  logic          ch_bad;

  assign prod     = 21'(idx_q) * 21'(RECIP_6);
  assign q6       = 11'({2'b00, pos_q} * 11'd6);
  assign len_cw   = CW'(len_q);
  assign pos_cw   = CW'(pos_q);
  assign idx_cw   = CW'(idx_q);
  assign addr_inc = addr_q + CW'(1);
  assign v_rd     = six_of(ram_rdata);
  assign v_hit    = v_rd & mask_q;
  assign addr_pw  = PW'(addr_q);
  assign base_bit = 12'(addr_pw[11:0] * 12'(BITS_PER_CHAR));
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign ch_bad   = (ch_q < CH_BASE) || (ch_q > CH_LAST);

  always_comb begin
    v_mod = v_rd & ~(6'b1 << bit_q);
    if (kind_q == KIND_SET) begin
      v_mod = v_rd | (6'b1 << bit_q);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = len_q[ADDR_W-1:0];
    ram_wdata = CH_SPACE;
    case (state_q)
      S_DISP: begin
        if (kind_q == KIND_APPEND && !ch_bad && len_cw < MAX_CW) begin
          ram_we    = 1'b1;
          ram_wdata = ch_q;
        end
      end
      S_PAD: begin
        ram_we = (len_cw <= pos_cw);
      end
      S_USE: begin
        if (kind_q == KIND_SET || kind_q == KIND_CLEAR) begin
          ram_we    = 1'b1;
          ram_waddr = addr_q[ADDR_W-1:0];
          ram_wdata = char_of(v_mod);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pbe_ram #(
    .WIDTH(8),
    .DEPTH(MAX_CHARS),
    .AW   (ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_q[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bits_q <= MAX_BITS_RST;
    end else if (cfg_we_i) begin
      max_bits_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      len_q      <= '0;
      m_valid_q  <= 1'b0;
      kind_q     <= KIND_EMPTY;
      idx_q      <= '0;
      ch_q       <= '0;
      pos_q      <= '0;
      bit_q      <= '0;
      addr_q     <= '0;
      mask_q     <= SIX_MASK;
      res_q      <= '0;
      cout_q     <= '0;
      status_q   <= ST_OK;
      m_res_q    <= '0;
      m_cout_q   <= '0;
      m_status_q <= '0;
      m_len_q    <= '0;
    end else begin
      // the output step below reloads the register in its own cycle
      if (m_valid_q && m_axis_tready_i && state_q != S_OUT) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            kind_q   <= kind_e'(s_axis_tuser_i);
            idx_q    <= s_axis_tdata_i[10:0];
            ch_q     <= s_axis_tdata_i[18:11];
            res_q    <= '0;
            cout_q   <= '0;
            status_q <= ST_OK;
            mask_q   <= SIX_MASK;
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          pos_q   <= prod[RECIP_SHIFT+8:RECIP_SHIFT];
          state_q <= S_REM;
        end
        S_REM: begin
          bit_q   <= 3'(idx_q - q6);
          state_q <= S_DISP;
        end
        S_DISP: begin
          state_q <= S_OUT;
          case (kind_q)
            KIND_APPEND: begin
              if (ch_bad) begin
                status_q <= ST_BADCHAR;
              end else if (len_cw >= MAX_CW) begin
                status_q <= ST_FULL;
              end else begin
                len_q <= len_q + LEN_W'(1);
              end
            end
            KIND_TEST: begin
              addr_q <= pos_cw;
              if (pos_cw < len_cw) begin
                state_q <= S_RD;
              end
            end
            KIND_NEXT: begin
              res_q <= RES_NONE;
              if (len_q != '0 && pos_cw < len_cw) begin
                if (idx_q == '0) begin
                  addr_q  <= '0;
                  state_q <= S_RD;
                end else if (bit_q == 3'd5) begin
                  addr_q <= pos_cw + CW'(1);
                  if (pos_cw + CW'(1) < len_cw) begin
                    state_q <= S_RD;
                  end
                end else begin
                  addr_q  <= pos_cw;
                  mask_q  <= 6'(SIX_MASK << (bit_q + 3'd1));
                  state_q <= S_RD;
                end
              end
            end
            KIND_SET: begin
              addr_q <= pos_cw;
              if (idx_q > max_bits_q) begin
                status_q <= ST_RANGE;
              end else if (pos_cw >= MAX_CW) begin
                status_q <= ST_FULL;
              end else begin
                state_q <= S_PAD;
              end
            end
            KIND_CLEAR: begin
              addr_q <= pos_cw;
              if (idx_q > max_bits_q) begin
                status_q <= ST_RANGE;
              end else if (pos_cw < len_cw) begin
                state_q <= S_RD;
              end
            end
            KIND_READ: begin
              addr_q <= idx_cw;
              if (idx_cw < len_cw) begin
                state_q <= S_RD;
              end
            end
            KIND_EMPTY: begin
              len_q <= '0;
            end
            default: begin
              state_q <= S_OUT;
            end
          endcase
        end
        S_PAD: begin
          // spaces go in until the target character exists
          if (len_cw <= pos_cw) begin
            len_q <= len_q + LEN_W'(1);
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_USE;
        end
        S_USE: begin
          state_q <= S_OUT;
          case (kind_q)
            KIND_TEST: begin
              res_q <= {11'b0, v_rd[bit_q]};
            end
            KIND_READ: begin
              cout_q <= ram_rdata;
            end
            KIND_NEXT: begin
              if (v_hit != '0) begin
                res_q <= base_bit + 12'(lowest_bit(v_hit));
              end else begin
                mask_q <= SIX_MASK;
                addr_q <= addr_inc;
                if (addr_inc < len_cw) begin
                  state_q <= S_RD;
                end
              end
            end
            default: begin
              state_q <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_res_q    <= res_q;
            m_cout_q   <= cout_q;
            m_status_q <= status_q;
            m_len_q    <= len_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OD_W'({m_len_q, m_cout_q, m_res_q});
  assign m_axis_tuser_o  = m_status_q;

  // length never runs past the store
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_CHARS))
    else $error("string length exceeds store depth");

  // a result only appears after the output step of a command
  a_result_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_OUT))
    else $error("result without a finished command");

  // one command at a time
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second command taken while busy");

  // the store is written only while a command is being worked on
  a_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE && state_q != S_OUT))
    else $error("store write outside a command");

endmodule
